[hdl/grs_pkg.sv]
// ----------------------------------------------------------------------------
// grs_pkg: shared definitions for the group reverse stream
// Default sizes, configuration register format and the group descriptor
// and bank release types passed between the front and back parts.
// ----------------------------------------------------------------------------
package grs_pkg;

	// default sizes handed to the top level parameters
	localparam int MAX_GROUP_DEFAULT   = 16;
	localparam int VALUE_WIDTH_DEFAULT = 32;

	// group size register
	localparam int               GROUP_SIZE_W     = 5;
	localparam logic [GROUP_SIZE_W-1:0] GROUP_SIZE_RESET = 5'd3;

	// entries in the descriptor queue between front and back
	localparam int DESC_DEPTH = 2;

	// flags of one completed group; the value count travels beside it
	typedef struct packed {
		logic bank;      // buffer bank holding the group
		logic reversed;  // group is full: drain newest first
		logic seq_last;  // group closes the sequence
	} desc_flags_t;

	// back part hands a drained bank back to the front part
	typedef struct packed {
		logic valid;
		logic bank;
	} bank_release_t;

endpackage

[hdl/grs_if.sv]
// ----------------------------------------------------------------------------
// grs_if: channel interfaces of the group reverse stream
// Input item, result item and configuration write channels, each with
// valid, ready and payload, and source and sink modports.
// ----------------------------------------------------------------------------

// input items: one value per transfer, flag on the final value
interface grs_item_if #(
	parameter int VALUE_WIDTH = grs_pkg::VALUE_WIDTH_DEFAULT
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;
	logic                          list_last;

	modport source (output valid, output value, output list_last, input ready);
	modport sink   (input valid, input value, input list_last, output ready);
endinterface

// result items: reordered values with group and sequence end flags
interface grs_result_if #(
	parameter int VALUE_WIDTH = grs_pkg::VALUE_WIDTH_DEFAULT
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] out_value;
	logic                          run_last;
	logic                          sequence_end;

	modport source (output valid, output out_value, output run_last,
		output sequence_end, input ready);
	modport sink   (input valid, input out_value, input run_last,
		input sequence_end, output ready);
endinterface

// configuration writes of the group size register
interface grs_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [grs_pkg::GROUP_SIZE_W-1:0]     group_size;

	modport source (output valid, output group_size, input ready);
	modport sink   (input valid, input group_size, output ready);
endinterface

[hdl/grs_desc_fifo.sv]
// ----------------------------------------------------------------------------
// grs_desc_fifo: descriptor queue between front and back
// Short first-in first-out queue of completed group descriptors; the head
// entry is visible to the back part until it is popped.
// ----------------------------------------------------------------------------
module grs_desc_fifo #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = grs_pkg::DESC_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              head_valid,
	output logic [DATA_W-1:0] head_data,
	input  logic              pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] entries_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	// flags
	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = entries_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop & head_valid;

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[hdl/grs_front.sv]
// ----------------------------------------------------------------------------
// grs_front: item intake and group classification
// Holds the group size register, writes each accepted value into the open
// bank, and on a full group or the sequence end queues a descriptor and
// moves to the other bank.
// ----------------------------------------------------------------------------
module grs_front #(
	parameter int MAX_GROUP   = grs_pkg::MAX_GROUP_DEFAULT,
	parameter int VALUE_WIDTH = grs_pkg::VALUE_WIDTH_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	grs_item_if.sink                               items,
	grs_cfg_if.sink                                cfg,
	// buffer write port
	output logic                                   wr_en,
	output logic                                   wr_bank,
	output logic [((MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1)-1:0] wr_idx,
	output logic [VALUE_WIDTH-1:0]                 wr_data,
	// descriptor queue
	output logic                                   push_valid,
	input  logic                                   push_ready,
	output grs_pkg::desc_flags_t                   push_flags,
	output logic [$clog2(MAX_GROUP + 1)-1:0]       push_count,
	// drained bank from the back part
	input  grs_pkg::bank_release_t                 release_in
);

	localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int CW = $clog2(MAX_GROUP + 1);
	localparam int KW = (CW > grs_pkg::GROUP_SIZE_W) ? CW : grs_pkg::GROUP_SIZE_W;

	logic [grs_pkg::GROUP_SIZE_W-1:0] group_size_q;
	logic [CW-1:0]                    fill_q;
	logic                             bank_q;
	logic [1:0]                       busy_q;
	logic [1:0]                       busy_d;
	logic [KW-1:0]                    size_ext;
	logic [KW-1:0]                    eff_size;
	logic [KW-1:0]                    n_ext;
	logic                             accept;
	logic                             group_full;
	logic                             complete;

	// configuration writes are always taken
	assign cfg.ready = 1'b1;

	// open bank must be free and the queue must have room
	assign items.ready = ~busy_q[bank_q] & push_ready;
	assign accept      = items.valid & items.ready;

	// effective group size: zero acts as one, large values saturate
	assign size_ext = KW'(group_size_q);
	always_comb begin
		eff_size = size_ext;
		if (size_ext == '0) begin
			eff_size = KW'(1);
		end else if (size_ext > KW'(MAX_GROUP)) begin
			eff_size = KW'(MAX_GROUP);
		end
	end

	// classify the incoming value
	assign n_ext      = KW'(fill_q) + KW'(1);
	assign group_full = (n_ext >= eff_size);
	assign complete   = group_full | items.list_last;

	// buffer write
	assign wr_en   = accept;
	assign wr_bank = bank_q;
	assign wr_idx  = fill_q[AW-1:0];
	assign wr_data = items.value;

	// descriptor of a closed group
	assign push_valid          = accept & complete;
	assign push_flags.bank     = bank_q;
	assign push_flags.reversed = group_full;
	assign push_flags.seq_last = items.list_last;
	assign push_count          = CW'(n_ext);

	// bank ownership: drained bank freed, closed bank taken
	always_comb begin
		busy_d = busy_q;
		if (release_in.valid) begin
			busy_d[release_in.bank] = 1'b0;
		end
		if (accept && complete) begin
			busy_d[bank_q] = 1'b1;
		end
	end

	// group size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= grs_pkg::GROUP_SIZE_RESET;
		end else if (cfg.valid) begin
			group_size_q <= cfg.group_size;
		end
	end

	// fill count, open bank and bank ownership
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			busy_q <= busy_d;
			if (accept) begin
				if (complete) begin
					fill_q <= '0;
					bank_q <= ~bank_q;
				end else begin
					fill_q <= fill_q + CW'(1);
				end
			end
		end
	end

	// a released bank was handed over earlier
	a_release_busy: assert property (@(posedge clk) disable iff (!arst_n)
		release_in.valid |-> busy_q[release_in.bank])
		else $error("release of a bank that is not busy");

	// the open group never reaches the bank size
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CW'(MAX_GROUP))
		else $error("fill count out of range");

	// a bank still draining has no new values in it
	a_busy_empty: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q[bank_q] |-> (fill_q == '0))
		else $error("values written into a draining bank");

endmodule

[hdl/grs_back.sv]
// ----------------------------------------------------------------------------
// grs_back: group drain sequencer
// Owns the two-bank group buffer, walks the head descriptor one value per
// cycle unless the output stalls, in reversed or arrival order, and presents
// each value from a registered read stage that also serves as the output register.
// ----------------------------------------------------------------------------
module grs_back #(
	parameter int MAX_GROUP   = grs_pkg::MAX_GROUP_DEFAULT,
	parameter int VALUE_WIDTH = grs_pkg::VALUE_WIDTH_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// buffer write port from the front part
	input  logic                                   wr_en,
	input  logic                                   wr_bank,
	input  logic [((MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1)-1:0] wr_idx,
	input  logic [VALUE_WIDTH-1:0]                 wr_data,
	// head of the descriptor queue
	input  logic                                   head_valid,
	input  grs_pkg::desc_flags_t                   head_flags,
	input  logic [$clog2(MAX_GROUP + 1)-1:0]       head_count,
	output logic                                   pop,
	output grs_pkg::bank_release_t                 release_out,
	grs_result_if.source                           results
);

	localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int CW = $clog2(MAX_GROUP + 1);
	localparam int MEM_DEPTH = 2 * (1 << AW);

	logic [VALUE_WIDTH-1:0] mem [MEM_DEPTH];
	logic [AW-1:0]          idx_q;
	logic                   valid_s1;
	logic [VALUE_WIDTH-1:0] data_s1;
	logic                   run_last_s1;
	logic                   seq_end_s1;
	logic                   advance;
	logic                   issue;
	logic                   last_issue;
	logic [CW-1:0]          cnt_m1;
	logic [AW-1:0]          rd_idx;

	// read sequencing
	assign advance    = ~valid_s1 | results.ready;
	assign issue      = advance & head_valid;
	assign cnt_m1     = head_count - CW'(1);
	assign last_issue = issue & (CW'(idx_q) == cnt_m1);
	assign rd_idx     = head_flags.reversed ? (cnt_m1[AW-1:0] - idx_q) : idx_q;

	// the last read frees the descriptor and its bank
	assign pop               = last_issue;
	assign release_out.valid = last_issue;
	assign release_out.bank  = head_flags.bank;

	// group buffer write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[{wr_bank, wr_idx}] <= wr_data;
		end
	end

	// registered read with flags
	always_ff @(posedge clk) begin
		if (issue) begin
			data_s1     <= mem[{head_flags.bank, rd_idx}];
			run_last_s1 <= last_issue;
			seq_end_s1  <= last_issue & head_flags.seq_last;
		end
	end

	// position in the group and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (issue) begin
				idx_q <= last_issue ? '0 : idx_q + AW'(1);
			end
			if (advance) begin
				valid_s1 <= issue;
			end
		end
	end

	// result channel
	assign results.valid        = valid_s1;
	assign results.out_value    = $signed(data_s1);
	assign results.run_last     = run_last_s1;
	assign results.sequence_end = seq_end_s1;

	// only a present descriptor is popped
	a_pop_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop of an empty descriptor queue");

	// sequence end only on the last value of a group
	a_seq_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && seq_end_s1) |-> run_last_s1)
		else $error("sequence end without group end");

	// position stays at the start while no group waits
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> (idx_q == '0))
		else $error("drain position moved without a group");

	// position stays inside the group being drained
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (CW'(idx_q) < head_count))
		else $error("drain position beyond group length");

endmodule

[hdl/group_reverse_stream.sv]
// ----------------------------------------------------------------------------
// group_reverse_stream: reverses a value stream in groups of a set size
// Full groups leave newest first; a partial group at the end of the
// sequence leaves in arrival order.
//
//   channel   dir   handshake       payload
//   items     in    valid/ready     value, list_last
//   results   out   valid/ready     out_value, run_last, sequence_end
//   cfg       in    valid/ready     group_size (always ready)
//
// One value is accepted per cycle while intake is not stalled, and one result
// leaves per cycle while the receiver is ready; the drain sequencer's single
// read port on the group buffer sets that rate. A group's first result is
// offered after its descriptor passes the queue and the registered read stage.
// Two buffer banks let one group fill while the previous one drains;
// intake stalls only when both banks still hold undrained groups.
// Reset clears the fill count, bank ownership and queue and loads group
// size 3; buffer contents are not cleared.
// ----------------------------------------------------------------------------
module group_reverse_stream #(
	parameter int MAX_GROUP   = grs_pkg::MAX_GROUP_DEFAULT,
	parameter int VALUE_WIDTH = grs_pkg::VALUE_WIDTH_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	grs_item_if.sink     items,
	grs_result_if.source results,
	grs_cfg_if.sink      cfg
);

	localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int CW = $clog2(MAX_GROUP + 1);
	localparam int FW = $bits(grs_pkg::desc_flags_t);
	localparam int DW = FW + CW;

	logic                   wr_en;
	logic                   wr_bank;
	logic [AW-1:0]          wr_idx;
	logic [VALUE_WIDTH-1:0] wr_data;
	logic                   push_valid;
	logic                   push_ready;
	grs_pkg::desc_flags_t   push_flags;
	logic [CW-1:0]          push_count;
	logic                   head_valid;
	logic [DW-1:0]          head_data;
	grs_pkg::desc_flags_t   head_flags;
	logic [CW-1:0]          head_count;
	logic                   pop;
	grs_pkg::bank_release_t bank_release;

	// intake and classification
	grs_front #(
		.MAX_GROUP   (MAX_GROUP),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.items       (items),
		.cfg         (cfg),
		.wr_en       (wr_en),
		.wr_bank     (wr_bank),
		.wr_idx      (wr_idx),
		.wr_data     (wr_data),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_flags  (push_flags),
		.push_count  (push_count),
		.release_in  (bank_release)
	);

	// descriptor queue
	grs_desc_fifo #(
		.DATA_W (DW),
		.DEPTH  (grs_pkg::DESC_DEPTH)
	) u_desc_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_flags, push_count}),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop)
	);

	// unpack the head descriptor
	assign head_flags = grs_pkg::desc_flags_t'(head_data[DW-1:CW]);
	assign head_count = head_data[CW-1:0];

	// drain sequencer and group buffer
	grs_back #(
		.MAX_GROUP   (MAX_GROUP),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_bank     (wr_bank),
		.wr_idx      (wr_idx),
		.wr_data     (wr_data),
		.head_valid  (head_valid),
		.head_flags  (head_flags),
		.head_count  (head_count),
		.pop         (pop),
		.release_out (bank_release),
		.results     (results)
	);

endmodule

[dv/group_reverse_stream_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_reverse_stream_test: self-checking bench for the group reverse stream
// A short table of directed steps, followed by random sequences over many
// group sizes. Each accepted value is run through a local model of the group
// buffer, and every result transfer is checked against the oldest expected
// result. Both sides idle in short random bursts, and one long receiver
// hold-off fills both buffer banks so that the input stalls.
// ----------------------------------------------------------------------------
module group_reverse_stream_test;

	localparam int MAX_G        = grs_pkg::MAX_GROUP_DEFAULT;
	localparam int VW           = grs_pkg::VALUE_WIDTH_DEFAULT;
	localparam int RANDOM_ITEMS = 220;
	localparam int CALM_FROM    = 150;
	localparam int SETTLE       = 8;
	localparam int HOLD_CYCLES  = 150;
	localparam int CYCLE_LIMIT  = 200000;

	typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

	typedef struct packed {
		logic signed [VW-1:0] out_value;
		logic                 run_last;
		logic                 sequence_end;
	} result_t;

	// one row of the directed table; cfg rows carry the size in value
	typedef struct {
		step_kind_t  kind;
		logic [VW-1:0] value;
		logic        last;
		logic        fixed;
		result_t     want;
	} stim_row_t;

	// note travelling with each offered value: a typed-in result or none
	typedef struct {
		logic    fixed;
		result_t want;
	} item_note_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	grs_item_if   #(.VALUE_WIDTH(VW)) items_ch ();
	grs_result_if #(.VALUE_WIDTH(VW)) results_ch ();
	grs_cfg_if                        cfg_ch ();

	group_reverse_stream #(
		.MAX_GROUP   (MAX_G),
		.VALUE_WIDTH (VW)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (results_ch),
		.cfg     (cfg_ch)
	);

	// local copy of the block state
	logic [grs_pkg::GROUP_SIZE_W-1:0] size_reg = grs_pkg::GROUP_SIZE_RESET;
	logic signed [VW-1:0]    held [MAX_G];
	int unsigned             held_count = 0;

	result_t    pending_results [$];
	item_note_t item_notes [$];
	stim_row_t  stim_table [$];

	int error_count   = 0;
	int items_taken   = 0;
	int results_seen  = 0;
	int size_writes   = 0;
	int random_sent   = 0;
	int cycle_count   = 0;
	int stall_left    = 0;
	int idle_level    = 2;
	logic hold_request = 1'b0;
	logic hold_active  = 1'b0;

	always #5 clk = ~clk;

	// group size as the block applies it
	function automatic int unsigned span_of(logic [grs_pkg::GROUP_SIZE_W-1:0] sz);
		if (sz == 0)
			return 1;
		if (sz > MAX_G)
			return MAX_G;
		return 32'(sz);
	endfunction

	// store one value, and queue whatever it releases when publish is set
	task automatic reorder_values(input logic signed [VW-1:0] v, input logic last,
		input logic publish);
		int unsigned span;
		int unsigned n;
		result_t     r;
		span = span_of(size_reg);
		if (held_count >= MAX_G)
			held_count = MAX_G - 1;
		held[held_count] = v;
		held_count++;
		n = held_count;
		if (n >= span || last) begin
			for (int unsigned i = 0; i < n; i++) begin
				r.out_value    = (n >= span) ? held[n - 1 - i] : held[i];
				r.run_last     = (i + 1 == n);
				r.sequence_end = (i + 1 == n) && last;
				if (publish)
					pending_results.push_back(r);
			end
			held_count = 0;
		end
	endtask

	// directed table builders
	function automatic void add_item(logic [VW-1:0] v, logic last);
		stim_row_t row;
		row.kind  = STEP_ITEM;
		row.value = v;
		row.last  = last;
		row.fixed = 1'b0;
		row.want  = '0;
		stim_table.push_back(row);
	endfunction

	// pass-through row whose single result is typed in
	function automatic void add_fixed(logic [VW-1:0] v, logic last);
		stim_row_t row;
		row.kind  = STEP_ITEM;
		row.value = v;
		row.last  = last;
		row.fixed = 1'b1;
		row.want  = '{out_value: v, run_last: 1'b1, sequence_end: last};
		stim_table.push_back(row);
	endfunction

	function automatic void add_size(logic [grs_pkg::GROUP_SIZE_W-1:0] sz);
		stim_row_t row;
		row.kind  = STEP_CFG;
		row.value = VW'(sz);
		row.last  = 1'b0;
		row.fixed = 1'b0;
		row.want  = '0;
		stim_table.push_back(row);
	endfunction

	// random value with a bias towards the extremes
	function automatic logic [VW-1:0] pick_value();
		case ($urandom_range(0, 15))
			0: return {1'b1, {(VW-1){1'b0}}};
			1: return {1'b0, {(VW-1){1'b1}}};
			2: return '0;
			3: return '1;
			default: return VW'($urandom());
		endcase
	endfunction

	// offer one value and wait for its transfer; entered and left at a clock edge
	task automatic send_item(input logic [VW-1:0] v, input logic last,
		input logic fixed, input result_t want);
		int gap;
		if (idle_level != 0 && $urandom_range(0, 7) < idle_level) begin
			gap = $urandom_range(1, 4);
			items_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_notes.push_back('{fixed: fixed, want: want});
		items_ch.valid     <= 1'b1;
		items_ch.value     <= v;
		items_ch.list_last <= last;
		do @(posedge clk); while (!items_ch.ready);
	endtask

	// drop valid and let the block drain before touching the register
	task automatic wait_drained();
		items_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_size(input logic [grs_pkg::GROUP_SIZE_W-1:0] sz);
		wait_drained();
		cfg_ch.valid      <= 1'b1;
		cfg_ch.group_size <= sz;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		size_writes++;
	endtask

	// whole sequence with the flag on its final value
	task automatic send_sequence(input int len);
		for (int i = 0; i < len; i++) begin
			send_item(pick_value(), i == len - 1, 1'b0, '0);
			random_sent++;
		end
	endtask

	// transfer monitor: register writes, prediction, result checking
	always @(posedge clk) begin
		item_note_t note;
		result_t    want;
		if (cfg_ch.valid && cfg_ch.ready)
			size_reg = cfg_ch.group_size;
		if (items_ch.valid && items_ch.ready) begin
			note = '{fixed: 1'b0, want: '0};
			if (item_notes.size() != 0)
				note = item_notes.pop_front();
			reorder_values(items_ch.value, items_ch.list_last, !note.fixed);
			if (note.fixed)
				pending_results.push_back(note.want);
			items_taken++;
		end
		if (results_ch.valid && results_ch.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result out_value %h run_last %b sequence_end %b",
					$time, results_ch.out_value, results_ch.run_last,
					results_ch.sequence_end);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (results_ch.out_value !== want.out_value) begin
					$display("%0t: out_value expected %h actual %h",
						$time, want.out_value, results_ch.out_value);
					error_count++;
				end
				if (results_ch.run_last !== want.run_last) begin
					$display("%0t: run_last expected %b actual %b",
						$time, want.run_last, results_ch.run_last);
					error_count++;
				end
				if (results_ch.sequence_end !== want.sequence_end) begin
					$display("%0t: sequence_end expected %b actual %b",
						$time, want.sequence_end, results_ch.sequence_end);
					error_count++;
				end
			end
		end
	end

	// receiver: random stall bursts, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_active) begin
			results_ch.ready <= 1'b0;
		end else if (stall_left != 0) begin
			results_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_level != 0 && $urandom_range(0, 7) < idle_level) begin
			results_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 3);
		end else begin
			results_ch.ready <= 1'b1;
		end
	end

	// long hold-off of the receiver, counted here
	initial begin
		wait (hold_request);
		@(posedge clk);
		hold_active <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active <= 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: no progress after %0d cycles", $time, CYCLE_LIMIT);
			$display("group_reverse_stream_test: FAIL");
			$finish;
		end
	end

	// stimulus
	initial begin
		int unsigned phase_sizes [$];
		int          phase_items;
		int          phase_sent;
		int          len;
		logic [grs_pkg::GROUP_SIZE_W-1:0] sz;
		stim_row_t   row;

		items_ch.valid      <= 1'b0;
		items_ch.value      <= '0;
		items_ch.list_last  <= 1'b0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.group_size   <= grs_pkg::GROUP_SIZE_RESET;

		// reset size 3: one full group reversed, then a partial one in order
		add_item(32'h0000_0011, 1'b0);
		add_item(32'h0000_0022, 1'b0);
		add_item(32'h0000_0033, 1'b0);
		add_item(32'h0000_0044, 1'b0);
		add_item(32'h0000_0055, 1'b1);
		// pass-through with the value extremes
		add_size(5'd1);
		add_fixed(32'h8000_0000, 1'b0);
		add_fixed(32'h7fff_ffff, 1'b1);
		add_fixed(32'h0000_0000, 1'b0);
		add_fixed(32'hffff_ffff, 1'b0);
		// size zero behaves as pass-through
		add_size(5'd0);
		add_fixed(32'h5a5a_5a5a, 1'b1);
		// size lowered with two values held
		add_size(5'd4);
		add_item(32'h0000_0101, 1'b0);
		add_item(32'h0000_0202, 1'b0);
		add_size(5'd2);
		add_item(32'h0000_0303, 1'b0);
		add_item(32'h0000_0404, 1'b1);
		// full group closing the sequence
		add_item(32'hcafe_0001, 1'b0);
		add_item(32'hcafe_0002, 1'b1);
		// sizes above the buffer depth saturate
		add_size(5'd17);
		add_item(32'h1234_5678, 1'b0);
		add_item(32'h8765_4321, 1'b0);
		add_item(32'hdead_beef, 1'b1);
		add_size(5'd31);
		add_item(32'h0f0f_0f0f, 1'b0);
		add_item(32'hf0f0_f0f0, 1'b1);
		// one-value sequence
		add_size(5'd3);
		add_item(32'h7777_7777, 1'b1);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (stim_table[i]) begin
			row = stim_table[i];
			if (row.kind == STEP_CFG)
				write_size(row.value[grs_pkg::GROUP_SIZE_W-1:0]);
			else
				send_item(row.value, row.last, row.fixed, row.want);
		end

		// random phases, the first one with the long receiver hold-off
		phase_sizes = '{16, 1, 2, 31, 5, 0, 7, 17, 4, 3, 9};
		while (random_sent < RANDOM_ITEMS) begin
			if (phase_sizes.size() != 0)
				sz = grs_pkg::GROUP_SIZE_W'(phase_sizes.pop_front());
			else
				sz = grs_pkg::GROUP_SIZE_W'($urandom_range(0, 31));
			write_size(sz);
			phase_items = 25;
			if (random_sent >= CALM_FROM || size_writes == 1 + 6 ||
				(sz == 16 && !hold_request))
				idle_level <= 0;
			else
				idle_level <= $urandom_range(0, 3);
			if (sz == 16 && !hold_request) begin
				hold_request <= 1'b1;
				phase_items  = 48;
			end
			phase_sent = 0;
			while (phase_sent < phase_items) begin
				if ($urandom_range(0, 5) == 0)
					len = 1;
				else
					len = $urandom_range(1, 2 * span_of(sz) + 2);
				send_sequence(len);
				phase_sent += len;
			end
			// now and then leave a group open across the next size change
			if (random_sent < CALM_FROM && $urandom_range(0, 2) == 0) begin
				len = $urandom_range(1, 3);
				for (int i = 0; i < len; i++) begin
					send_item(pick_value(), 1'b0, 1'b0, '0);
					random_sent++;
				end
			end
		end

		// close any open group, then drain
		send_item(pick_value(), 1'b1, 1'b0, '0);
		wait_drained();
		repeat (20) @(posedge clk);

		$display("run covered %0d values and %0d results over %0d group size writes,",
			items_taken, results_seen, size_writes);
		$display("sizes 0, 1, 16, 17 and 31, a size change with a group open, and a long stall");
		if (error_count == 0 && pending_results.size() == 0)
			$display("group_reverse_stream_test: PASS");
		else
			$display("group_reverse_stream_test: FAIL");
		$finish;
	end

endmodule
